// ===== rtl/rhpc_pkg.sv =====
// Shared types, constants and functions of the rolling hash pattern counter.
// No dependencies; used by rhpc_cell, the top level and the checker.
package rhpc_pkg;

  localparam int unsigned MaxPattern = 8;   // default and upper limit of MAX_PATTERN
  localparam int unsigned LenW       = 4;   // width of the pattern length register
  localparam int unsigned PatW       = 64;  // width of the packed pattern register
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WeightW    = 12;  // 3^7 = 2187 fits in 12 bits
  localparam int unsigned ProdW      = ByteW + WeightW;
  localparam int unsigned SumW       = ProdW + 3;
  localparam int unsigned HashW      = 64;
  localparam int unsigned CountW     = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLength = 1'b0,
    RegPatternBytes  = 1'b1
  } cfg_reg_e;

  // Control that the top level hands to every cell of the window row.
  typedef struct packed {
    logic adv;  // a text beat is taken this cycle
    logic clr;  // that beat ends the text, so the row clears behind it
  } cell_ctrl_t;

  // Powers of the hash base.
  function automatic logic [WeightW-1:0] pow3(input logic [2:0] k);
    logic [WeightW-1:0] w;
    unique case (k)
      3'd0:    w = 12'd1;
      3'd1:    w = 12'd3;
      3'd2:    w = 12'd9;
      3'd3:    w = 12'd27;
      3'd4:    w = 12'd81;
      3'd5:    w = 12'd243;
      3'd6:    w = 12'd729;
      default: w = 12'd2187;
    endcase
    return w;
  endfunction

  // Hash of the first len pattern characters, character k weighted by 3^k.
  function automatic logic [HashW-1:0] pattern_hash(input logic [PatW-1:0] pat,
                                                    input logic [LenW-1:0] len);
    logic [SumW-1:0] acc;
    acc = '0;
    for (int unsigned k = 0; k < 8; k++) begin
      if (LenW'(k) < len) begin
        acc = acc + SumW'(ProdW'(pat[k*ByteW +: ByteW]) * ProdW'(pow3(3'(k))));
      end
    end
    return HashW'(acc);
  endfunction

endpackage

// ===== rtl/rhpc_cell.sv =====
// One cell of the sliding window row: holds one text byte and scores it.
// Depends on rhpc_pkg.
module rhpc_cell import rhpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [ByteW-1:0]   byte_i,      // byte moving in from the newer neighbor
  input  logic               active_i,    // cell lies inside the pattern length
  input  logic [ByteW-1:0]   pat_byte_i,  // pattern character aligned with this cell
  input  logic [WeightW-1:0] weight_i,    // hash weight of this cell's position
  output logic [ByteW-1:0]   byte_o,      // stored byte, handed to the older neighbor
  output logic               eq_o,        // registered compare result
  output logic [ProdW-1:0]   prod_o       // registered hash term
);

  logic [ByteW-1:0] win_q, win_d;
  logic             eq_q, eq_d;
  logic [ProdW-1:0] prod_q, prod_d;

  always_comb begin
    win_d  = win_q;
    eq_d   = eq_q;
    prod_d = prod_q;
    if (ctrl_i.adv) begin
      win_d  = ctrl_i.clr ? '0 : byte_i;
      eq_d   = !active_i || (byte_i == pat_byte_i);
      prod_d = active_i ? ProdW'(byte_i) * ProdW'(weight_i) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eq_q   <= eq_d;
    prod_q <= prod_d;
  end

  assign byte_o = win_q;
  assign eq_o   = eq_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/rolling_hash_pattern_counter.sv =====
// Top level of the rolling hash pattern counter: config registers, window row, scoring stage.
// Depends on rhpc_pkg and rhpc_cell.
//
// Text enters one byte per beat and every byte yields exactly one result beat. The
// block takes one byte per clock cycle while in_ready_o is high. Each taken byte is
// first shifted into the row of window cells, where each cell compares its new byte
// with its pattern character and registers its weighted hash term; then the terms are
// summed, the window hash is checked against the pattern hash, all byte compares are
// checked, and the match flag and saturating count are registered in the output
// stage. The output stage holds while its result waits unread, and the first stage
// holds only when it has a byte and the output stage is holding, so a byte can still
// enter whenever the first stage is empty or the output register is empty or being
// read. A match needs the current text to have supplied at least pattern_length
// bytes. The result of a byte marked end_of_text carries text_done, and the window,
// byte count and match count start fresh for the next byte. Registers must be written
// by the user only while the block is idle; the block itself does not enforce this:
// index 0 is pattern_length (0 acts as 1, values above MAX_PATTERN act as
// MAX_PATTERN) and index 1 holds the packed pattern, character k in bits 8k+7..8k.
module rolling_hash_pattern_counter import rhpc_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPattern
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PatW-1:0]    cfg_wdata_i,
  // text beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   text_byte_i,
  input  logic               end_of_text_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               match_here_o,
  output logic [CountW-1:0]  match_count_o,
  output logic               text_done_o
);

  localparam int unsigned SeenW = $clog2(MAX_PATTERN + 1);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(MAX_PATTERN);

  // Configuration registers.
  logic [LenW-1:0] len_q;
  logic [PatW-1:0] pat_q;
  logic [LenW-1:0] len_eff;
  logic [HashW-1:0] phash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegPatternLength: len_q <= cfg_wdata_i[LenW-1:0];
        RegPatternBytes:  pat_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(MAX_PATTERN)) begin
      len_eff = LenW'(MAX_PATTERN);
    end else begin
      len_eff = len_q;
    end
  end

  // The pattern hash only follows the registers, so it is kept registered.
  always_ff @(posedge clk_i) begin
    phash_q <= pattern_hash(pat_q, len_eff);
  end

  // Pipeline control: both stages advance when the output register can take a result.
  logic advance;
  logic accept;
  logic a_vld_q;
  logic a_last_q;
  logic a_seen_ok_q;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !a_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  cell_ctrl_t cell_ctrl;
  assign cell_ctrl.adv = accept;
  assign cell_ctrl.clr = end_of_text_i;

  // Bytes of the current text, saturating at the window depth.
  logic [SeenW-1:0] seen_q, seen_d, seen_next;

  assign seen_next = (seen_q == SeenMax) ? seen_q : seen_q + SeenW'(1);

  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      seen_d = end_of_text_i ? '0 : seen_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      a_vld_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      if (in_ready_o) begin
        a_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_last_q    <= end_of_text_i;
      a_seen_ok_q <= LenW'(seen_next) >= len_eff;
    end
  end

  // Window row: cell 0 takes the newest byte, cell i holds the byte i places back.
  logic [ByteW-1:0] cell_byte [MAX_PATTERN];
  logic             cell_eq   [MAX_PATTERN];
  logic [ProdW-1:0] cell_prod [MAX_PATTERN];

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [LenW-1:0]  pos;     // age of this cell's byte within the window, oldest = 0
    logic             active;
    logic [ByteW-1:0] feed;

    assign active = LenW'(i) < len_eff;
    assign pos    = len_eff - LenW'(1) - LenW'(i);

    if (i == 0) begin : g_head
      assign feed = text_byte_i;
    end else begin : g_body
      assign feed = cell_byte[i-1];
    end

    rhpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (feed),
      .active_i   (active),
      .pat_byte_i (pat_q[pos[2:0]*ByteW +: ByteW]),
      .weight_i   (pow3(pos[2:0])),
      .byte_o     (cell_byte[i]),
      .eq_o       (cell_eq[i]),
      .prod_o     (cell_prod[i])
    );
  end

  // Scoring stage: window hash, hash check, byte check and count.
  logic [SumW-1:0]   whash_sum;
  logic              all_eq;
  logic              match;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_new;

  always_comb begin
    whash_sum = '0;
    all_eq    = 1'b1;
    for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
      whash_sum = whash_sum + SumW'(cell_prod[i]);
      all_eq    = all_eq && cell_eq[i];
    end
  end

  // Equal hashes alone never count; the byte compare has the final word.
  assign match   = a_seen_ok_q && (HashW'(whash_sum) == phash_q) && all_eq;
  assign cnt_new = (match && cnt_q != CountMax) ? cnt_q + CountW'(1) : cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (advance && a_vld_q) begin
      cnt_d = a_last_q ? '0 : cnt_new;
    end
  end

  logic              out_valid_q;
  logic              match_q;
  logic [CountW-1:0] count_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (advance) begin
        out_valid_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && a_vld_q) begin
      match_q <= match;
      count_q <= cnt_new;
      done_q  <= a_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_here_o  = match_q;
  assign match_count_o = count_q;
  assign text_done_o   = done_q;

endmodule

// ===== rtl/rhpc_checker.sv =====
// Port-level checks of the rolling hash pattern counter, bound to the top level.
// Depends on rhpc_pkg and rolling_hash_pattern_counter.
module rhpc_checker import rhpc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               match_here_o,
  input logic [CountW-1:0]  match_count_o,
  input logic               text_done_o
);

  // A result beat that is held back keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_count_o)
      && $stable(match_here_o) && $stable(text_done_o))
    else $error("result beat changed while stalled");

  // A match is always counted.
  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_here_o |-> match_count_o != '0)
    else $error("match reported with a zero count");

  // With no result waiting the block always takes text.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  // Consecutive results of one text never lower the count.
  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !text_done_o ##1 out_valid_o
      |-> match_count_o >= $past(match_count_o))
    else $error("match count went down within a text");

endmodule

bind rolling_hash_pattern_counter rhpc_checker u_rhpc_checker (.*);
